// ===== hw/rtl/nugly_pkg.sv =====
// Shared constants and types for the ugly number table block.
package nugly_pkg;

  localparam int MAX_N  = 1024;
  localparam int IDX_W  = $clog2(MAX_N);
  localparam int POS_W  = 11;
  localparam int VAL_W  = 31;
  localparam int C2_W   = VAL_W + 1;
  localparam int C3_W   = VAL_W + 2;
  localparam int CAND_W = VAL_W + 3;

  // result of one merge step
  typedef struct packed {
    logic [VAL_W-1:0] next_val;
    logic             adv2;
    logic             adv3;
    logic             adv5;
  } cand_res_t;

endpackage

// ===== hw/rtl/nugly_store.sv =====
// Sequence table: one write port, one read port, registered read data.
module nugly_store (
  input  logic                          clk,
  input  logic                          we,
  input  logic [nugly_pkg::IDX_W-1:0]   waddr,
  input  logic [nugly_pkg::VAL_W-1:0]   wdata,
  input  logic [nugly_pkg::IDX_W-1:0]   raddr,
  output logic [nugly_pkg::VAL_W-1:0]   rdata
);
  import nugly_pkg::*;

  logic [VAL_W-1:0] mem [MAX_N];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/nugly_cand.sv =====
// Merge step: forms the quintuple candidate, picks the minimum, flags pointers to advance.
module nugly_cand (
  input  logic [nugly_pkg::C2_W-1:0]  c2,
  input  logic [nugly_pkg::C3_W-1:0]  c3,
  input  logic [nugly_pkg::VAL_W-1:0] v5,
  output nugly_pkg::cand_res_t        res
);
  import nugly_pkg::*;

  logic [CAND_W-1:0] c2_x;
  logic [CAND_W-1:0] c3_x;
  logic [CAND_W-1:0] c5_x;
  logic [CAND_W-1:0] m23;
  logic [CAND_W-1:0] m_all;

  always_comb begin
    c2_x  = CAND_W'(c2);
    c3_x  = CAND_W'(c3);
    c5_x  = CAND_W'(v5) + CAND_W'({v5, 2'b00});
    m23   = (c2_x < c3_x) ? c2_x : c3_x;
    m_all = (m23 < c5_x) ? m23 : c5_x;
    res.next_val = m_all[VAL_W-1:0];
    res.adv2     = (c2_x == m_all);
    res.adv3     = (c3_x == m_all);
    res.adv5     = (c5_x == m_all);
  end

endmodule

// ===== hw/rtl/nugly_ctrl.sv =====
// Sequencer: rebuilds the table per request through the store and returns the last entry.
module nugly_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nugly_pkg::POS_W-1:0]   in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nugly_pkg::VAL_W-1:0]   out_ugly_value,
  output logic                          out_range_error
);
  import nugly_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_CAP2, ST_CAP3, ST_CALC, ST_DONE
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] last_idx_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] p2_r, p3_r, p5_r;
  logic [IDX_W-1:0] p2_nxt;
  logic [C2_W-1:0]  c2_r;
  logic [C3_W-1:0]  c3_r;
  logic             fwd_r;
  logic [VAL_W-1:0] fwd_val_r;
  logic [VAL_W-1:0] res_val_r;
  logic             res_err_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_val_r;
  logic             out_err_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_rdata;
  logic [VAL_W-1:0] v2;
  logic             pos_bad;
  cand_res_t        cand;

  nugly_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  nugly_cand u_cand (
    .c2  (c2_r),
    .c3  (c3_r),
    .v5  (mem_rdata),
    .res (cand)
  );

  assign p2_nxt  = p2_r + IDX_W'(cand.adv2);
  // entry just written in the previous cycle comes from the bypass register
  assign v2      = fwd_r ? fwd_val_r : mem_rdata;
  assign pos_bad = (in_position == '0) || (in_position > POS_W'(MAX_N));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = cand.next_val;
    mem_raddr = '0;
    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = VAL_W'(1);
        mem_raddr = '0;
      end
      ST_CAP2: mem_raddr = p3_r;
      ST_CAP3: mem_raddr = p5_r;
      ST_CALC: begin
        mem_we    = 1'b1;
        mem_raddr = p2_nxt;
      end
      default: mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      // in ST_DONE the load below decides out_valid_r
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (pos_bad) begin
              res_val_r <= '0;
              res_err_r <= 1'b1;
              state_r   <= ST_DONE;
            end else begin
              last_idx_r <= IDX_W'(in_position - POS_W'(1));
              state_r    <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          if (last_idx_r == '0) begin
            res_val_r <= VAL_W'(1);
            res_err_r <= 1'b0;
            state_r   <= ST_DONE;
          end else begin
            idx_r     <= IDX_W'(1);
            p2_r      <= '0;
            p3_r      <= '0;
            p5_r      <= '0;
            fwd_r     <= 1'b1;
            fwd_val_r <= VAL_W'(1);
            state_r   <= ST_CAP2;
          end
        end
        ST_CAP2: begin
          c2_r    <= {v2, 1'b0};
          fwd_r   <= 1'b0;
          state_r <= ST_CAP3;
        end
        ST_CAP3: begin
          c3_r    <= C3_W'(mem_rdata) + C3_W'({mem_rdata, 1'b0});
          state_r <= ST_CALC;
        end
        ST_CALC: begin
          p2_r <= p2_nxt;
          p3_r <= p3_r + IDX_W'(cand.adv3);
          p5_r <= p5_r + IDX_W'(cand.adv5);
          if (idx_r == last_idx_r) begin
            res_val_r <= cand.next_val;
            res_err_r <= 1'b0;
            state_r   <= ST_DONE;
          end else begin
            idx_r     <= idx_r + IDX_W'(1);
            fwd_r     <= (p2_nxt == idx_r);
            fwd_val_r <= cand.next_val;
            state_r   <= ST_CAP2;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_val_r;
            out_err_r   <= res_err_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ugly_value  = out_val_r;
  assign out_range_error = out_err_r;

endmodule

// ===== hw/rtl/nth_ugly_number_merge_table.sv =====
// The result for position n follows the rebuild of the table up to entry n-1, each entry after
// the first taking states ST_CAP2, ST_CAP3 and ST_CALC; out-of-range positions skip the rebuild.
// One request is in work at a time. Per entry the single read port of the table is used three
// times, which sets the rate. The output register holds a finished result while the next
// request is taken, but no new request is taken before the last one has left ST_DONE. Reset
// (rst_n, synchronous, low) clears control; the table needs no clearing.
module nth_ugly_number_merge_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nugly_pkg::POS_W-1:0]   in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nugly_pkg::VAL_W-1:0]   out_ugly_value,
  output logic                          out_range_error
);
  import nugly_pkg::*;

  nugly_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ugly_value  (out_ugly_value),
    .out_range_error (out_range_error)
  );

endmodule

// ===== hw/rtl/nugly_chk.sv =====
// Port-level checks for the ugly number block, bound to the top level.
module nugly_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [nugly_pkg::POS_W-1:0]   in_position,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [nugly_pkg::VAL_W-1:0]   out_ugly_value,
  input logic                          out_range_error
);
  import nugly_pkg::*;

  // a waiting request holds until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_position))
    else $error("request changed while stalled");

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ugly_value)
      && $stable(out_range_error))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_ugly_value == '0)
    else $error("error result carries a value");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |-> out_ugly_value != '0)
    else $error("good result is zero");

  // one request at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after input transfer");

endmodule

bind nth_ugly_number_merge_table nugly_chk u_nugly_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_position     (in_position),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_ugly_value  (out_ugly_value),
  .out_range_error (out_range_error)
);

// ===== test/tb_nth_ugly_number_merge_table.sv =====
`timescale 1ns / 1ps
// Testbench for nth_ugly_number_merge_table: random and corner positions checked against a table model.
module tb_nth_ugly_number_merge_table;
  import nugly_pkg::*;

  localparam logic [POS_W-1:0] POS_TOP = '1;
  localparam int               DRAIN_CYCLES = 20;

  // Rebuilds the ugly-number table per request, like the block, and queues the answer.
  class ugly_scoreboard;
    typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             error;
    } ugly_answer_t;

    bit [VAL_W-1:0] seq_table [MAX_N];
    int unsigned    ptr_two, ptr_three, ptr_five, filled;
    ugly_answer_t   answers_q [$];
    int             errors;

    function void note_position(logic [POS_W-1:0] pos);
      ugly_answer_t      ans;
      longint unsigned   c2, c3, c5, nxt;
      if (pos == 0 || pos > MAX_N) begin
        // out of range: flag only, table untouched
        ans.value = '0;
        ans.error = 1'b1;
      end else begin
        seq_table[0] = 1;
        ptr_two   = 0;
        ptr_three = 0;
        ptr_five  = 0;
        for (int i = 1; i < pos; i++) begin
          c2  = 2 * longint'(seq_table[ptr_two]);
          c3  = 3 * longint'(seq_table[ptr_three]);
          c5  = 5 * longint'(seq_table[ptr_five]);
          nxt = (c2 < c3) ? c2 : c3;
          nxt = (c5 < nxt) ? c5 : nxt;
          seq_table[i] = nxt[VAL_W-1:0];
          // every matching pointer moves so duplicates are skipped
          if (c2 == nxt) ptr_two++;
          if (c3 == nxt) ptr_three++;
          if (c5 == nxt) ptr_five++;
        end
        filled    = pos;
        ans.value = seq_table[pos-1];
        ans.error = 1'b0;
      end
      answers_q.push_back(ans);
    endfunction

    function void check_result(logic [VAL_W-1:0] value, logic error);
      ugly_answer_t exp_ans;
      if (answers_q.size() == 0) begin
        $error("unexpected result: ugly_value %0d range_error %0b", value, error);
        errors++;
        return;
      end
      exp_ans = answers_q.pop_front();
      if (value !== exp_ans.value) begin
        $error("ugly_value: expected %0d, got %0d", exp_ans.value, value);
        errors++;
      end
      if (error !== exp_ans.error) begin
        $error("range_error: expected %0b, got %0b", exp_ans.error, error);
        errors++;
      end
    endfunction

    function int pending();
      return answers_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [POS_W-1:0] in_position;
  logic             out_valid;
  logic             out_ready;
  logic [VAL_W-1:0] out_ugly_value;
  logic             out_range_error;

  bit               no_idle;
  ugly_scoreboard   sb = new();

  nth_ugly_number_merge_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ugly_value (out_ugly_value),
    .out_range_error(out_range_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Mostly short tables; a few long ones and some out-of-range requests.
  function automatic logic [POS_W-1:0] random_position();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 4)  return '0;
    if (sel < 10) return POS_W'($urandom_range(MAX_N + 1, POS_TOP));
    if (sel < 65) return POS_W'($urandom_range(1, 48));
    if (sel < 88) return POS_W'($urandom_range(49, 300));
    return POS_W'($urandom_range(301, MAX_N));
  endfunction

  task automatic send_position(input logic [POS_W-1:0] pos);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    sb.note_position(pos);
  endtask

  // Hold off the sender until every queued answer has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    logic [POS_W-1:0] directed [$];
    directed = '{1, 2, 3, 4, 5, 6, 7, 8, 10, 11, 12, 0, MAX_N + 1, POS_TOP, 1536,
                 MAX_N, MAX_N - 1, 512, 341, 682, 1, 0, 100};
    in_valid    = 1'b0;
    in_position = '0;
    rst_n       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) begin
      send_position(directed[k]);
      if (k == 5) drain_results();
    end
    drain_results();

    for (int k = 0; k < 167; k++) begin
      if (k % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0) drain_results();
      send_position(random_position());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[nth_ugly_number_merge_table] OK");
    end else begin
      $display("[nth_ugly_number_merge_table] ERROR");
    end
    $finish;
  end

  // Result side: random stall before each transfer, checked at the rising edge.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      gap = draw_gap();
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_ugly_value, out_range_error);
    end
  end

  initial begin
    #(30_000_000);
    $display("[nth_ugly_number_merge_table] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/nugly_pkg.sv
hw/rtl/nugly_store.sv
hw/rtl/nugly_cand.sv
hw/rtl/nugly_ctrl.sv
hw/rtl/nth_ugly_number_merge_table.sv
hw/rtl/nugly_chk.sv
test/tb_nth_ugly_number_merge_table.sv
